// File: rtl/assert_macros.svh
// Assertion macros for the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_CLK(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rst_n, prop)
`define ASSERT_CLK(name, clk, prop)
`endif

`endif

// File: rtl/lsp_pkg.sv
package lsp_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int SENSOR_MAX       = 16;
  localparam int SENSOR_W         = 8;
  localparam int SENSOR_PITCH     = 30;
  localparam int LINE_CENTER      = 105;
  localparam int ERR_MAX          = 127;

  localparam int GAIN_W   = 16;
  localparam int Q_FRAC   = 8;
  localparam int MUL_IN_W = 14;
  localparam int MAG_W    = 13;
  localparam int PROD_W   = GAIN_W + MAG_W;
  localparam int PMAG_W   = PROD_W - Q_FRAC;
  localparam int ACC_W    = 24;
  localparam int MIX_W    = 13;
  localparam int UPC_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd512;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd3328;

  localparam logic signed [7:0]  INTEG_WIN = 8'sd30;
  localparam logic signed [13:0] SUM_HI    = 14'sd5000;
  localparam logic signed [13:0] SUM_LO    = -14'sd5000;
  localparam logic signed [10:0] STEER_HI  = 11'sd1023;
  localparam logic signed [10:0] STEER_LO  = -11'sd1023;
  localparam logic signed [12:0] CMD_MAX   = 13'sd255;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  localparam logic [1:0] DIR_BRAKE = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_REV   = 2'd2;

  localparam logic [UPC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] PC_SCAN   = 4'd1;
  localparam logic [UPC_W-1:0] PC_DIV    = 4'd2;
  localparam logic [UPC_W-1:0] PC_ERR    = 4'd3;
  localparam logic [UPC_W-1:0] PC_MUL_P  = 4'd4;
  localparam logic [UPC_W-1:0] PC_MUL_I  = 4'd5;
  localparam logic [UPC_W-1:0] PC_MUL_D  = 4'd6;
  localparam logic [UPC_W-1:0] PC_ACC    = 4'd7;
  localparam logic [UPC_W-1:0] PC_STORE  = 4'd8;
  localparam logic [UPC_W-1:0] PC_MIX    = 4'd9;
  localparam logic [UPC_W-1:0] PC_OUT    = 4'd10;
  localparam logic [UPC_W-1:0] PC_NOLINE = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_DIV,
    OP_ERR,
    OP_HOLD_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_STORE,
    OP_MIX,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_LINE,
    JMP_DIV_LOOP,
    JMP_IN_WAIT,
    JMP_OUT_WAIT
  } jump_t;

  typedef struct packed {
    op_t               op;
    acc_op_t           acc;
    jump_t             jump;
    logic [UPC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [7:0] duty;
  } wheel_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE:   w = '{OP_LOAD,     ACC_NONE, JMP_IN_WAIT,  PC_MIX};
      PC_SCAN:   w = '{OP_SCAN,     ACC_NONE, JMP_NO_LINE,  PC_NOLINE};
      PC_DIV:    w = '{OP_DIV,      ACC_NONE, JMP_DIV_LOOP, PC_DIV};
      PC_ERR:    w = '{OP_ERR,      ACC_NONE, JMP_NEXT,     PC_IDLE};
      PC_MUL_P:  w = '{OP_MUL_P,    ACC_NONE, JMP_NEXT,     PC_IDLE};
      PC_MUL_I:  w = '{OP_MUL_I,    ACC_LOAD, JMP_NEXT,     PC_IDLE};
      PC_MUL_D:  w = '{OP_MUL_D,    ACC_ADD,  JMP_NEXT,     PC_IDLE};
      PC_ACC:    w = '{OP_NOP,      ACC_SUB,  JMP_NEXT,     PC_IDLE};
      PC_STORE:  w = '{OP_STORE,    ACC_NONE, JMP_NEXT,     PC_IDLE};
      PC_MIX:    w = '{OP_MIX,      ACC_NONE, JMP_NEXT,     PC_IDLE};
      PC_OUT:    w = '{OP_OUT,      ACC_NONE, JMP_OUT_WAIT, PC_IDLE};
      PC_NOLINE: w = '{OP_HOLD_ERR, ACC_NONE, JMP_ALWAYS,   PC_MUL_P};
      default:   w = '{OP_NOP,      ACC_NONE, JMP_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/line_sensor_pid_differential_drive_core.sv
// Channel | Direction | Handshake          | Beat contents
// in      | input     | in_valid, in_stall | in_sensor_bits, in_update, in_base_speed
// out     | output    | out_valid, out_stall | wheel commands, line error, steering
// cfg     | input     | cfg_we             | cfg_addr selects a gain, cfg_wdata its value
// A beat with update high finds the line position with the one-bit-per-cycle restoring
// divider; with no sensor active the divider is skipped. A beat with update low goes
// straight from the input step to the mixing step.
// Reset is synchronous and returns the gains to their defaults and clears the controller.
// A stalled result holds the sequencer in its output step until the result is taken.
`include "assert_macros.svh"

module line_sensor_pid_differential_drive_core #(
  parameter int SENSOR_COUNT = lsp_pkg::SENSOR_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_sensor_bits,
  input  logic                                in_update,
  input  logic [7:0]                          in_base_speed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_left_dir,
  output logic [7:0]                          out_left_duty,
  output logic [1:0]                          out_right_dir,
  output logic [7:0]                          out_right_duty,
  output logic signed [7:0]                   out_line_error,
  output logic signed [10:0]                  out_steer_out,
  input  logic                                cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [lsp_pkg::GAIN_W-1:0]          cfg_wdata
);

  localparam int WSUM_MAX = lsp_pkg::SENSOR_PITCH * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
  localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
  localparam int CNT_W    = $clog2(SENSOR_COUNT + 1);
  localparam int DCNT_W   = $clog2(WSUM_W);
  localparam int DIFF_W   = ((WSUM_W > 8) ? WSUM_W : 8) + 2;

  localparam logic signed [DIFF_W-1:0] ERR_HI = $signed(DIFF_W'(lsp_pkg::ERR_MAX));
  localparam logic signed [DIFF_W-1:0] ERR_LO = -ERR_HI - $signed(DIFF_W'(1));
  localparam logic signed [DIFF_W-1:0] CENTER = $signed(DIFF_W'(lsp_pkg::LINE_CENTER));

  lsp_pkg::uword_t uw;

  logic [lsp_pkg::UPC_W-1:0]   pc_r, pc_nxt;
  logic [7:0]                  bits_r, bits_nxt;
  logic [7:0]                  base_r, base_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [WSUM_W-1:0]           quo_r, quo_nxt;
  logic [DCNT_W-1:0]           div_cnt_r, div_cnt_nxt;
  logic signed [7:0]           err_r, err_nxt;
  logic signed [7:0]           prev_r, prev_nxt;
  logic signed [13:0]          sum_r, sum_nxt;
  logic [lsp_pkg::PMAG_W-1:0]  prod_mag_r, prod_mag_nxt;
  logic                        prod_neg_r, prod_neg_nxt;
  logic signed [lsp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [10:0]          steer_r, steer_nxt;
  logic signed [lsp_pkg::MIX_W-1:0] left_r, left_nxt;
  logic signed [lsp_pkg::MIX_W-1:0] right_r, right_nxt;
  logic [lsp_pkg::GAIN_W-1:0]  gain_p_r, gain_p_nxt;
  logic [lsp_pkg::GAIN_W-1:0]  gain_i_r, gain_i_nxt;
  logic [lsp_pkg::GAIN_W-1:0]  gain_d_r, gain_d_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lsp_pkg::wheel_t             out_left_r, out_left_nxt;
  lsp_pkg::wheel_t             out_right_r, out_right_nxt;
  logic signed [7:0]           out_err_r, out_err_nxt;
  logic signed [10:0]          out_steer_r, out_steer_nxt;

  logic                        in_fire;
  logic                        slot_free;
  logic [lsp_pkg::SENSOR_MAX-1:0] bits_ext;
  logic [CNT_W-1:0]            cnt_comb;
  logic [WSUM_W-1:0]           wsum_comb;
  logic [CNT_W:0]              trial;
  logic                        trial_ge;
  logic signed [DIFF_W-1:0]    pos_diff;
  logic signed [7:0]           err_sat;
  logic                        integ_en;
  logic signed [14:0]          sum_ext;
  logic signed [13:0]          sum_sat;
  logic signed [8:0]           err_diff;
  logic [lsp_pkg::GAIN_W-1:0]  mul_gain;
  logic signed [lsp_pkg::MUL_IN_W-1:0] mul_in;
  logic [lsp_pkg::MUL_IN_W-1:0] mul_abs;
  logic [lsp_pkg::PROD_W-1:0]  prod_full;
  logic signed [lsp_pkg::ACC_W-1:0] prod_s;
  logic signed [10:0]          steer_sat;
  logic signed [lsp_pkg::MIX_W-1:0] ang, bse, base_a, base_b;

  function automatic lsp_pkg::wheel_t drive_f(input logic signed [lsp_pkg::MIX_W-1:0] cmd);
    lsp_pkg::wheel_t w;
    logic signed [lsp_pkg::MIX_W-1:0] mag;
    mag = -cmd;
    if (cmd == '0) begin
      w.dir  = lsp_pkg::DIR_BRAKE;
      w.duty = 8'd0;
    end else if (!cmd[lsp_pkg::MIX_W-1]) begin
      w.dir  = lsp_pkg::DIR_FWD;
      w.duty = (cmd > lsp_pkg::CMD_MAX) ? 8'hFF : cmd[7:0];
    end else begin
      w.dir  = lsp_pkg::DIR_REV;
      w.duty = (mag > lsp_pkg::CMD_MAX) ? 8'hFF : mag[7:0];
    end
    return w;
  endfunction

  assign uw        = lsp_pkg::ucode(pc_r);
  assign in_stall  = (pc_r != lsp_pkg::PC_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign bits_ext = {{(lsp_pkg::SENSOR_MAX - lsp_pkg::SENSOR_W){1'b0}}, bits_r};

  always_comb begin
    cnt_comb  = '0;
    wsum_comb = '0;
    for (int j = 0; j < SENSOR_COUNT; j++) begin
      if (bits_ext[SENSOR_COUNT-1-j]) begin
        cnt_comb  = cnt_comb + CNT_W'(1);
        wsum_comb = wsum_comb + WSUM_W'(j * lsp_pkg::SENSOR_PITCH);
      end
    end
  end

  assign trial    = {rem_r, quo_r[WSUM_W-1]};
  assign trial_ge = (trial >= {1'b0, cnt_r});

  assign pos_diff = $signed({{(DIFF_W - WSUM_W){1'b0}}, quo_r}) - CENTER;
  assign err_sat  = (pos_diff > ERR_HI) ? ERR_HI[7:0] :
                    (pos_diff < ERR_LO) ? ERR_LO[7:0] : pos_diff[7:0];

  assign integ_en = (err_r > -lsp_pkg::INTEG_WIN) && (err_r < lsp_pkg::INTEG_WIN);
  assign sum_ext  = 15'(sum_r) + 15'(err_r);
  assign sum_sat  = (sum_ext > lsp_pkg::SUM_HI) ? lsp_pkg::SUM_HI :
                    (sum_ext < lsp_pkg::SUM_LO) ? lsp_pkg::SUM_LO : sum_ext[13:0];

  assign err_diff = 9'(prev_r) - 9'(err_r);

  always_comb begin
    case (uw.op)
      lsp_pkg::OP_MUL_I: begin
        mul_gain = gain_i_r;
        mul_in   = sum_r;
      end
      lsp_pkg::OP_MUL_D: begin
        mul_gain = gain_d_r;
        mul_in   = 14'(err_diff);
      end
      default: begin
        mul_gain = gain_p_r;
        mul_in   = 14'(err_r);
      end
    endcase
  end

  assign mul_abs   = mul_in[lsp_pkg::MUL_IN_W-1] ? 14'(-mul_in) : 14'(mul_in);
  assign prod_full = lsp_pkg::PROD_W'(mul_gain) *
                     lsp_pkg::PROD_W'(mul_abs[lsp_pkg::MAG_W-1:0]);

  assign prod_s = prod_neg_r ?
                  -$signed({{(lsp_pkg::ACC_W - lsp_pkg::PMAG_W){1'b0}}, prod_mag_r}) :
                   $signed({{(lsp_pkg::ACC_W - lsp_pkg::PMAG_W){1'b0}}, prod_mag_r});

  assign steer_sat = (acc_r > lsp_pkg::STEER_HI) ? lsp_pkg::STEER_HI :
                     (acc_r < lsp_pkg::STEER_LO) ? lsp_pkg::STEER_LO : acc_r[10:0];

  // Lower the base so the outer wheel stays at full duty.
  assign ang    = 13'(steer_r);
  assign bse    = $signed({5'b0, base_r});
  assign base_a = (bse + ang > lsp_pkg::CMD_MAX) ? lsp_pkg::CMD_MAX - ang : bse;
  assign base_b = (base_a - ang > lsp_pkg::CMD_MAX) ? lsp_pkg::CMD_MAX + ang : base_a;

  always_comb begin
    pc_nxt        = pc_r;
    bits_nxt      = bits_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    err_nxt       = err_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    prod_mag_nxt  = prod_mag_r;
    prod_neg_nxt  = prod_neg_r;
    acc_nxt       = acc_r;
    steer_nxt     = steer_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    out_valid_nxt = out_valid_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_err_nxt   = out_err_r;
    out_steer_nxt = out_steer_r;

    if (cfg_we) begin
      case (cfg_addr)
        lsp_pkg::REG_GAIN_P: gain_p_nxt = cfg_wdata;
        lsp_pkg::REG_GAIN_I: gain_i_nxt = cfg_wdata;
        lsp_pkg::REG_GAIN_D: gain_d_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (uw.op)
      lsp_pkg::OP_LOAD: begin
        if (in_fire) begin
          bits_nxt = in_sensor_bits;
          base_nxt = in_base_speed;
        end
      end
      lsp_pkg::OP_SCAN: begin
        cnt_nxt     = cnt_comb;
        quo_nxt     = wsum_comb;
        rem_nxt     = '0;
        div_cnt_nxt = DCNT_W'(WSUM_W - 1);
      end
      lsp_pkg::OP_DIV: begin
        rem_nxt     = trial_ge ? CNT_W'(trial - {1'b0, cnt_r}) : trial[CNT_W-1:0];
        quo_nxt     = {quo_r[WSUM_W-2:0], trial_ge};
        div_cnt_nxt = div_cnt_r - DCNT_W'(1);
      end
      lsp_pkg::OP_ERR: begin
        err_nxt = err_sat;
      end
      lsp_pkg::OP_HOLD_ERR: begin
        err_nxt = prev_r;
      end
      lsp_pkg::OP_MUL_P: begin
        prod_mag_nxt = prod_full[lsp_pkg::PROD_W-1:lsp_pkg::Q_FRAC];
        prod_neg_nxt = mul_in[lsp_pkg::MUL_IN_W-1];
        if (integ_en) begin
          sum_nxt = sum_sat;
        end
      end
      lsp_pkg::OP_MUL_I, lsp_pkg::OP_MUL_D: begin
        prod_mag_nxt = prod_full[lsp_pkg::PROD_W-1:lsp_pkg::Q_FRAC];
        prod_neg_nxt = mul_in[lsp_pkg::MUL_IN_W-1];
      end
      lsp_pkg::OP_STORE: begin
        steer_nxt = steer_sat;
        prev_nxt  = err_r;
      end
      lsp_pkg::OP_MIX: begin
        left_nxt  = base_b + ang;
        right_nxt = base_b - ang;
      end
      lsp_pkg::OP_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = drive_f(left_r);
          out_right_nxt = drive_f(right_r);
          out_err_nxt   = prev_r;
          out_steer_nxt = steer_r;
        end
      end
      default: ;
    endcase

    case (uw.acc)
      lsp_pkg::ACC_LOAD: acc_nxt = prod_s;
      lsp_pkg::ACC_ADD:  acc_nxt = acc_r + prod_s;
      lsp_pkg::ACC_SUB:  acc_nxt = acc_r - prod_s;
      default: ;
    endcase

    case (uw.jump)
      lsp_pkg::JMP_NEXT:     pc_nxt = pc_r + lsp_pkg::UPC_W'(1);
      lsp_pkg::JMP_ALWAYS:   pc_nxt = uw.target;
      lsp_pkg::JMP_NO_LINE:  pc_nxt = (cnt_comb == '0) ? uw.target
                                                        : pc_r + lsp_pkg::UPC_W'(1);
      lsp_pkg::JMP_DIV_LOOP: pc_nxt = (div_cnt_r != '0) ? uw.target
                                                         : pc_r + lsp_pkg::UPC_W'(1);
      lsp_pkg::JMP_IN_WAIT: begin
        if (!in_fire) begin
          pc_nxt = pc_r;
        end else if (in_update) begin
          pc_nxt = pc_r + lsp_pkg::UPC_W'(1);
        end else begin
          pc_nxt = uw.target;
        end
      end
      lsp_pkg::JMP_OUT_WAIT: pc_nxt = slot_free ? uw.target : pc_r;
      default:               pc_nxt = lsp_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= lsp_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= lsp_pkg::GAIN_P_RST;
      gain_i_r    <= lsp_pkg::GAIN_I_RST;
      gain_d_r    <= lsp_pkg::GAIN_D_RST;
      prev_r      <= '0;
      sum_r       <= '0;
      steer_r     <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      steer_r     <= steer_nxt;
      bits_r      <= bits_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      quo_r       <= quo_nxt;
      div_cnt_r   <= div_cnt_nxt;
      err_r       <= err_nxt;
      prod_mag_r  <= prod_mag_nxt;
      prod_neg_r  <= prod_neg_nxt;
      acc_r       <= acc_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
      out_err_r   <= out_err_nxt;
      out_steer_r <= out_steer_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_dir   = out_left_r.dir;
  assign out_left_duty  = out_left_r.duty;
  assign out_right_dir  = out_right_r.dir;
  assign out_right_duty = out_right_r.duty;
  assign out_line_error = out_err_r;
  assign out_steer_out  = out_steer_r;

  `ASSERT_CLK(a_reset_idle, clk, !rst_n |=> (pc_r == lsp_pkg::PC_IDLE && !out_valid_r))
  `ASSERT_RST(a_steer_range, clk, rst_n, (steer_r <= lsp_pkg::STEER_HI && steer_r >= lsp_pkg::STEER_LO))
  `ASSERT_RST(a_hold_goes_mix, clk, rst_n, (in_valid && !in_stall && !in_update) |=> (pc_r == lsp_pkg::PC_MIX))
  `ASSERT_RST(a_result_from_out, clk, rst_n, $rose(out_valid_r) |-> ($past(pc_r) == lsp_pkg::PC_OUT))

endmodule
